// ===== hw/rtl/compressed_instruction_expander_top_macros.svh =====
// Assertion macros for the compressed instruction expander.
// Included by the RTL top module, which checks its own pipeline behavior.
// Assertions are dropped from synthesis builds.
`ifndef COMPRESSED_INSTRUCTION_EXPANDER_TOP_MACROS_SVH
`define COMPRESSED_INSTRUCTION_EXPANDER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define CIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/cie_pkg.sv =====
// Package for the compressed instruction expander: opcodes, funct3 codes,
// register numbers and the RV32C to RV32I expansion function.
// No dependencies.
package cie_pkg;

  localparam int unsigned CWordW = 16;
  localparam int unsigned XWordW = 32;

  // Compressed quadrants (low two bits)
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Base major opcodes
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // Base funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;

  // Base funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Compressed funct3 codes, quadrant 0
  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_SW       = 3'd6;

  // Compressed funct3 codes, quadrant 1
  localparam logic [2:0] C1_ADDI = 3'd0;
  localparam logic [2:0] C1_JAL  = 3'd1;
  localparam logic [2:0] C1_LI   = 3'd2;
  localparam logic [2:0] C1_LUI  = 3'd3;
  localparam logic [2:0] C1_ALU  = 3'd4;
  localparam logic [2:0] C1_J    = 3'd5;
  localparam logic [2:0] C1_BEQZ = 3'd6;
  localparam logic [2:0] C1_BNEZ = 3'd7;

  // Quadrant 1 ALU group selectors
  localparam logic [1:0] ALU_SRLI = 2'd0;
  localparam logic [1:0] ALU_SRAI = 2'd1;
  localparam logic [1:0] ALU_ANDI = 2'd2;
  localparam logic [1:0] ALU_REG  = 2'd3;
  localparam logic [1:0] REG_SUB  = 2'd0;
  localparam logic [1:0] REG_XOR  = 2'd1;
  localparam logic [1:0] REG_OR   = 2'd2;
  localparam logic [1:0] REG_AND  = 2'd3;

  // Compressed funct3 codes, quadrant 2
  localparam logic [2:0] C2_SLLI = 3'd0;
  localparam logic [2:0] C2_LWSP = 3'd2;
  localparam logic [2:0] C2_CR   = 3'd4;
  localparam logic [2:0] C2_SWSP = 3'd6;

  // Architectural register numbers
  localparam logic [4:0] REG_X0 = 5'd0;
  localparam logic [4:0] REG_RA = 5'd1;
  localparam logic [4:0] REG_SP = 5'd2;

  localparam logic [XWordW-1:0] BAD_WORD = '0;

  typedef struct packed {
    logic [XWordW-1:0] word;
    logic              illegal;
  } cie_result_t;

  function automatic logic [31:0] cie_mk_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                           logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] cie_mk_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                           logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] cie_mk_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                           logic [2:0] f3, logic [6:0] op);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  // Branch against x0; imm is the 13-bit byte offset
  function automatic logic [31:0] cie_mk_b(logic [12:0] imm, logic [4:0] rs1, logic [2:0] f3);
    return {imm[12], imm[10:5], REG_X0, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  // Jump; imm is the 21-bit byte offset
  function automatic logic [31:0] cie_mk_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] cie_quad0(logic [15:0] w);
    logic [4:0]  r_hi;
    logic [4:0]  r_lo;
    logic [6:0]  off;
    logic [9:0]  nzuimm;
    logic [31:0] r;
    r_hi   = {2'b01, w[9:7]};
    r_lo   = {2'b01, w[4:2]};
    off    = {w[5], w[12:10], w[6], 2'b00};
    nzuimm = {w[10:7], w[12:11], w[5], w[6], 2'b00};
    case (w[15:13])
      C0_ADDI4SPN: begin
        if (nzuimm == '0) r = BAD_WORD;
        else r = cie_mk_i({2'b00, nzuimm}, REG_SP, F3_ADD, r_lo, OPC_IMM);
      end
      C0_LW:   r = cie_mk_i({5'b0, off}, r_hi, F3_WORD, r_lo, OPC_LOAD);
      C0_SW:   r = cie_mk_s({5'b0, off}, r_lo, r_hi, F3_WORD, OPC_STORE);
      default: r = BAD_WORD;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] cie_quad1(logic [15:0] w);
    logic [4:0]  rd;
    logic [4:0]  r_hi;
    logic [4:0]  r_lo;
    logic [11:0] ci_sx;
    logic [11:0] jo;
    logic [20:0] jimm;
    logic [9:0]  spimm;
    logic [8:0]  boff;
    logic [2:0]  reg_f3;
    logic [6:0]  reg_f7;
    logic [31:0] r;
    rd     = w[11:7];
    r_hi   = {2'b01, w[9:7]};
    r_lo   = {2'b01, w[4:2]};
    ci_sx  = {{6{w[12]}}, w[12], w[6:2]};
    jo     = {w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
    jimm   = {{9{w[12]}}, jo};
    spimm  = {w[12], w[4:3], w[5], w[2], w[6], 4'b0000};
    boff   = {w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
    reg_f7 = F7_BASE;
    reg_f3 = F3_ADD;
    case (w[6:5])
      REG_SUB: reg_f7 = F7_ALT;
      REG_XOR: reg_f3 = F3_XOR;
      REG_OR:  reg_f3 = F3_OR;
      REG_AND: reg_f3 = F3_AND;
      default: reg_f3 = F3_ADD;
    endcase
    case (w[15:13])
      C1_ADDI: r = cie_mk_i(ci_sx, rd, F3_ADD, rd, OPC_IMM);
      C1_JAL:  r = cie_mk_j(jimm, REG_RA);
      C1_LI:   r = cie_mk_i(ci_sx, REG_X0, F3_ADD, rd, OPC_IMM);
      C1_LUI: begin
        if (rd == REG_SP) begin
          if (spimm == '0) r = BAD_WORD;
          else r = cie_mk_i({{2{w[12]}}, spimm}, REG_SP, F3_ADD, REG_SP, OPC_IMM);
        end else if ({w[12], w[6:2]} == 6'd0) begin
          r = BAD_WORD;
        end else begin
          r = {{14{w[12]}}, w[12], w[6:2], rd, OPC_LUI};
        end
      end
      C1_ALU: begin
        case (w[11:10])
          ALU_SRLI, ALU_SRAI: begin
            // shamt bit 5 is RV64 only
            if (w[12]) r = BAD_WORD;
            else r = cie_mk_i({1'b0, w[10], 5'b0, w[6:2]}, r_hi, F3_SR, r_hi, OPC_IMM);
          end
          ALU_ANDI: r = cie_mk_i(ci_sx, r_hi, F3_AND, r_hi, OPC_IMM);
          default: begin
            // SUBW and ADDW are RV64 only
            if (w[12]) r = BAD_WORD;
            else r = cie_mk_r(reg_f7, r_lo, r_hi, reg_f3, r_hi, OPC_OP);
          end
        endcase
      end
      C1_J:    r = cie_mk_j(jimm, REG_X0);
      C1_BEQZ: r = cie_mk_b({{4{w[12]}}, boff}, r_hi, F3_BEQ);
      default: r = cie_mk_b({{4{w[12]}}, boff}, r_hi, F3_BNE);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] cie_quad2(logic [15:0] w);
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [7:0]  lw_off;
    logic [7:0]  sw_off;
    logic [31:0] r;
    rd     = w[11:7];
    rs2    = w[6:2];
    lw_off = {w[3:2], w[12], w[6:4], 2'b00};
    sw_off = {w[8:7], w[12:9], 2'b00};
    case (w[15:13])
      C2_SLLI: begin
        if (w[12]) r = BAD_WORD;
        else r = cie_mk_i({7'b0, rs2}, rd, F3_SLL, rd, OPC_IMM);
      end
      C2_LWSP: begin
        if (rd == REG_X0) r = BAD_WORD;
        else r = cie_mk_i({4'b0, lw_off}, REG_SP, F3_WORD, rd, OPC_LOAD);
      end
      C2_CR: begin
        if (!w[12]) begin
          if (rs2 != REG_X0) r = cie_mk_r(F7_BASE, rs2, REG_X0, F3_ADD, rd, OPC_OP);
          else if (rd == REG_X0) r = BAD_WORD;
          else r = cie_mk_i(12'd0, rd, F3_ADD, REG_X0, OPC_JALR);
        end else begin
          if (rs2 != REG_X0) r = cie_mk_r(F7_BASE, rs2, rd, F3_ADD, rd, OPC_OP);
          else if (rd == REG_X0) r = cie_mk_i(12'd1, REG_X0, F3_ADD, REG_X0, OPC_SYSTEM);
          else r = cie_mk_i(12'd0, rd, F3_ADD, REG_RA, OPC_JALR);
        end
      end
      C2_SWSP: r = cie_mk_s({4'b0, sw_off}, rs2, REG_SP, F3_WORD, OPC_STORE);
      default: r = BAD_WORD;
    endcase
    return r;
  endfunction

  // Expand one compressed word; a zero result marks it illegal
  function automatic cie_result_t cie_expand(logic [CWordW-1:0] w);
    cie_result_t res;
    case (w[1:0])
      QUAD_0:  res.word = cie_quad0(w);
      QUAD_1:  res.word = cie_quad1(w);
      QUAD_2:  res.word = cie_quad2(w);
      default: res.word = BAD_WORD;
    endcase
    res.illegal = (res.word == BAD_WORD);
    return res;
  endfunction

endpackage

// ===== hw/rtl/compressed_instruction_expander_top.sv =====
// Top level of the RV32C instruction expander: input register, expansion
// logic and result register with stall handling.
// Depends on cie_pkg and compressed_instruction_expander_top_macros.svh.
//
//   channel   | dir | payload                          | handshake
//   s_axis    | in  | tdata[15:0] compressed_word      | tvalid / tready
//   m_axis    | out | tdata[31:0] expanded_word,       | tvalid / tready
//             |     | tuser[0] illegal                 |
//
// One beat per cycle sustained while the output is not stalled; a result
// passes through the input register, then the result register.
// Reset clears both valid flags; payload registers are not reset.
// A stalled output holds its beat; the input register keeps accepting
// while the result register is empty or draining in the same cycle.
`include "compressed_instruction_expander_top_macros.svh"

module compressed_instruction_expander_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] compressed_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] expanded_word
  output logic        m_axis_tuser    // [0] illegal
);
  import cie_pkg::*;

  logic              in_vld_q, in_vld_d;
  logic [CWordW-1:0] word_q;
  logic              out_vld_q, out_vld_d;
  logic [XWordW-1:0] exp_q;
  logic              ill_q;
  logic              s_beat;
  logic              out_load_ok;
  logic              out_load;
  cie_result_t       exp_res;

  // Result register can take a beat when empty or draining
  assign out_load_ok   = !out_vld_q || m_axis_tready;
  assign out_load      = out_load_ok && in_vld_q;
  assign s_axis_tready = !in_vld_q || out_load_ok;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = s_beat || (in_vld_q && !out_load_ok);
  assign out_vld_d = out_load_ok ? in_vld_q : out_vld_q;

  // Expand the registered word
  assign exp_res = cie_expand(word_q);

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture input and result payloads
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      word_q <= s_axis_tdata;
    end
    if (out_load) begin
      exp_q <= exp_res.word;
      ill_q <= exp_res.illegal;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = exp_q;
  assign m_axis_tuser  = ill_q;

  `CIE_ASSERT_NOW(a_ill_flag_match, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tuser == (m_axis_tdata == BAD_WORD), "illegal flag disagrees with word")
  `CIE_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !in_vld_q, s_axis_tready,
    "input stalled with empty input register")
  `CIE_ASSERT_NEXT(a_beat_held, clk_i, rst_ni, s_beat, in_vld_q,
    "accepted beat lost from input register")
  `CIE_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, out_load,
    m_axis_tvalid && (m_axis_tdata == $past(exp_res.word)), "result register not loaded")

endmodule

// ===== test/compressed_instruction_expander_top_tb.sv =====
// Self-checking bench for compressed_instruction_expander_top: drives RV32C words
// over the input stream and checks each expanded beat against its own expansion model.
// Depends only on the RTL of compressed_instruction_expander_top.
module compressed_instruction_expander_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned QUIET_ITEMS  = 300;
  localparam int unsigned BURST_ITEMS  = 24;
  localparam int unsigned LONG_HOLD    = 40;
  localparam int unsigned REPORT_LIMIT = 10;

  // Quadrants
  localparam logic [1:0] Q0 = 2'd0;
  localparam logic [1:0] Q1 = 2'd1;
  localparam logic [1:0] Q2 = 2'd2;

  // Base opcodes
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_ST     = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BR     = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_SYS    = 7'h73;

  // Base funct3 / funct7
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_SW  = 3'd2;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR  = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Compressed funct3 per quadrant
  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_SW       = 3'd6;
  localparam logic [2:0] C1_ADDI     = 3'd0;
  localparam logic [2:0] C1_JAL      = 3'd1;
  localparam logic [2:0] C1_LI       = 3'd2;
  localparam logic [2:0] C1_LUI      = 3'd3;
  localparam logic [2:0] C1_MISC     = 3'd4;
  localparam logic [2:0] C1_J        = 3'd5;
  localparam logic [2:0] C1_BEQZ     = 3'd6;
  localparam logic [2:0] C2_SLLI     = 3'd0;
  localparam logic [2:0] C2_LWSP     = 3'd2;
  localparam logic [2:0] C2_CR       = 3'd4;
  localparam logic [2:0] C2_SWSP     = 3'd6;

  // Quadrant 1 arithmetic group selectors
  localparam logic [1:0] SEL_SRLI = 2'd0;
  localparam logic [1:0] SEL_SRAI = 2'd1;
  localparam logic [1:0] SEL_ANDI = 2'd2;
  localparam logic [1:0] RO_SUB   = 2'd0;
  localparam logic [1:0] RO_XOR   = 2'd1;
  localparam logic [1:0] RO_OR    = 2'd2;

  // Registers and fixed values
  localparam logic [4:0]  X_ZERO       = 5'd0;
  localparam logic [4:0]  X_RA         = 5'd1;
  localparam logic [4:0]  X_SP         = 5'd2;
  localparam logic [11:0] EBREAK_IMM   = 12'd1;
  localparam logic [31:0] ILLEGAL_WORD = 32'd0;

  // Extremes, every operation but a legal C.SLLI, and the reserved forms
  localparam logic [15:0] DIRECTED_WORDS [0:34] = '{
    16'h0000, 16'h1FFC, 16'h5FFC, 16'hDFFC, 16'hFFFE, 16'hFFFF, 16'h1FFD,
    16'h3FFD, 16'h4001, 16'h6101, 16'h717D, 16'h6081, 16'h7FFD, 16'h9001,
    16'h83FD, 16'h87FD, 16'h9BFD, 16'h8C01, 16'h8C21, 16'h8C41, 16'h8FFD,
    16'h9C01, 16'hBFFD, 16'hC001, 16'hFFFD, 16'h1002, 16'h4002, 16'h5FFE,
    16'h8002, 16'h8F82, 16'h8FFE, 16'h9002, 16'h9082, 16'h9FFE, 16'hDFFE
  };

  typedef struct packed {
    logic [15:0] cword;
    logic [31:0] word;
    logic        illegal;
  } expansion_t;

  // Base instruction formats
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_ST};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs1, logic [2:0] f3);
    return {imm[12], imm[10:5], X_ZERO, rs1, f3, imm[4:1], imm[11], OP_BR};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  class expansion_scoreboard;
    expansion_t  expected_expansions[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Work out the 32-bit form of one compressed word
    function expansion_t expand_rvc(logic [15:0] w);
      expansion_t  e;
      logic [4:0]  rd;
      logic [4:0]  rs2;
      logic [4:0]  rp_hi;
      logic [4:0]  rp_lo;
      logic [11:0] ci_ext;
      logic [11:0] jmp12;
      logic [8:0]  br9;
      logic [9:0]  imm10;
      logic [7:0]  sp_off;
      logic [6:0]  word_off;
      logic [31:0] r;
      rd       = w[11:7];
      rs2      = w[6:2];
      rp_hi    = {2'b01, w[9:7]};
      rp_lo    = {2'b01, w[4:2]};
      ci_ext   = {{6{w[12]}}, w[12], w[6:2]};
      word_off = {w[5], w[12:10], w[6], 2'b00};
      jmp12    = {w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
      br9      = {w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
      r        = ILLEGAL_WORD;
      case (w[1:0])
        Q0: begin
          case (w[15:13])
            C0_ADDI4SPN: begin
              imm10 = {w[10:7], w[12:11], w[5], w[6], 2'b00};
              if (imm10 != '0) r = enc_i({2'b00, imm10}, X_SP, F3_ADD, rp_lo, OP_IMM);
            end
            C0_LW: r = enc_i({5'b0, word_off}, rp_hi, F3_LW, rp_lo, OP_LOAD);
            C0_SW: r = enc_s({5'b0, word_off}, rp_lo, rp_hi, F3_SW);
            default: ;
          endcase
        end
        Q1: begin
          case (w[15:13])
            C1_ADDI: r = enc_i(ci_ext, rd, F3_ADD, rd, OP_IMM);
            C1_JAL:  r = enc_j({{9{jmp12[11]}}, jmp12}, X_RA);
            C1_LI:   r = enc_i(ci_ext, X_ZERO, F3_ADD, rd, OP_IMM);
            C1_LUI: begin
              if (rd == X_SP) begin
                // stack adjust in multiples of 16
                imm10 = {w[12], w[4:3], w[5], w[2], w[6], 4'b0000};
                if (imm10 != '0) begin
                  r = enc_i({{2{imm10[9]}}, imm10}, X_SP, F3_ADD, X_SP, OP_IMM);
                end
              end else if ({w[12], w[6:2]} != 6'd0) begin
                r = {{8{ci_ext[11]}}, ci_ext, rd, OP_LUI};
              end
            end
            C1_MISC: begin
              case (w[11:10])
                SEL_SRLI, SEL_SRAI: begin
                  if (!w[12]) begin
                    r = enc_i({1'b0, w[10], 5'b0, w[6:2]}, rp_hi, F3_SR, rp_hi, OP_IMM);
                  end
                end
                SEL_ANDI: r = enc_i(ci_ext, rp_hi, F3_AND, rp_hi, OP_IMM);
                default: begin
                  if (!w[12]) begin
                    case (w[6:5])
                      RO_SUB:  r = enc_r(F7_ALT, rp_lo, rp_hi, F3_ADD, rp_hi);
                      RO_XOR:  r = enc_r(F7_BASE, rp_lo, rp_hi, F3_XOR, rp_hi);
                      RO_OR:   r = enc_r(F7_BASE, rp_lo, rp_hi, F3_OR, rp_hi);
                      default: r = enc_r(F7_BASE, rp_lo, rp_hi, F3_AND, rp_hi);
                    endcase
                  end
                end
              endcase
            end
            C1_J: r = enc_j({{9{jmp12[11]}}, jmp12}, X_ZERO);
            default: begin
              r = enc_b({{4{br9[8]}}, br9}, rp_hi, (w[15:13] == C1_BEQZ) ? F3_BEQ : F3_BNE);
            end
          endcase
        end
        Q2: begin
          case (w[15:13])
            C2_SLLI: begin
              if (!w[12]) r = enc_i({7'b0, rs2}, rd, F3_SLL, rd, OP_IMM);
            end
            C2_LWSP: begin
              sp_off = {w[3:2], w[12], w[6:4], 2'b00};
              if (rd != X_ZERO) r = enc_i({4'b0, sp_off}, X_SP, F3_LW, rd, OP_LOAD);
            end
            C2_CR: begin
              if (!w[12]) begin
                if (rs2 != X_ZERO) r = enc_r(F7_BASE, rs2, X_ZERO, F3_ADD, rd);
                else if (rd != X_ZERO) r = enc_i(12'd0, rd, F3_ADD, X_ZERO, OP_JALR);
              end else begin
                if (rs2 != X_ZERO) r = enc_r(F7_BASE, rs2, rd, F3_ADD, rd);
                else if (rd == X_ZERO) r = enc_i(EBREAK_IMM, X_ZERO, F3_ADD, X_ZERO, OP_SYS);
                else r = enc_i(12'd0, rd, F3_ADD, X_RA, OP_JALR);
              end
            end
            C2_SWSP: begin
              sp_off = {w[8:7], w[12:9], 2'b00};
              r = enc_s({4'b0, sp_off}, rs2, X_SP, F3_SW);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      e.cword   = w;
      e.word    = r;
      e.illegal = (r == ILLEGAL_WORD);
      return e;
    endfunction

    // Queue the expansion of an accepted input beat
    function void note_input(logic [15:0] w);
      expected_expansions.push_back(expand_rvc(w));
    endfunction

    // Compare an output beat with the oldest pending expansion
    function void check_result(logic [31:0] word, logic illegal);
      expansion_t e;
      if (expected_expansions.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("[%0t] unexpected output beat %h illegal=%b", $realtime, word, illegal);
        end
        return;
      end
      e = expected_expansions.pop_front();
      if (word !== e.word || illegal !== e.illegal) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("[%0t] mismatch for %h: expected %h illegal=%b, got %h illegal=%b",
                   $realtime, e.cword, e.word, e.illegal, word, illegal);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  bit idle_en = 1'b1;
  bit stall_request = 1'b0;
  expansion_scoreboard sb;

  compressed_instruction_expander_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Give up after a generous bound
  initial begin
    #2_000_000;
    $display("compressed_instruction_expander_top verification failed");
    $finish;
  end

  // Mostly legal quadrants, some with zeroed fields to reach the reserved forms
  function automatic logic [15:0] random_word();
    logic [15:0] w;
    int unsigned mode;
    w    = 16'($urandom);
    mode = $urandom_range(0, 9);
    if (mode < 8) w[1:0] = 2'($urandom_range(0, 2));
    if (mode >= 5 && mode < 8) begin
      if ($urandom_range(0, 1) == 0) w[6:2] = '0;
      if ($urandom_range(0, 1) == 0) w[11:7] = '0;
      if ($urandom_range(0, 1) == 0) w[12] = 1'b0;
    end
    return w;
  endfunction

  // Offer one beat from a falling edge and hold it until accepted
  task automatic send_word(input logic [15:0] w, input bit may_gap);
    if (may_gap && idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = w;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(w);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every pending expansion to come out
  task automatic drain_all();
    s_axis_tvalid = 1'b0;
    while (sb.expected_expansions.size() != 0) @(negedge clk_i);
  endtask

  // Output side: random short stalls, or one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        stall_request = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Check every output beat at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Stimulus
  initial begin
    int unsigned n;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED_WORDS[i]) send_word(DIRECTED_WORDS[i], 1'b1);

    // Back up the block behind a long output hold, then let it empty
    stall_request = 1'b1;
    for (n = 0; n < BURST_ITEMS; n++) send_word(random_word(), 1'b0);
    drain_all();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_en = 1'b0;
      send_word(random_word(), 1'b1);
    end
    s_axis_tvalid = 1'b0;

    for (n = 0; n < 1000 && sb.expected_expansions.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.failures == 0 && sb.expected_expansions.size() == 0) begin
      $display("compressed_instruction_expander_top verification clean");
    end else begin
      $display("compressed_instruction_expander_top verification failed");
    end
    $finish;
  end

endmodule

// ===== compressed_instruction_expander_top.f =====
+incdir+hw/rtl
hw/rtl/cie_pkg.sv
hw/rtl/compressed_instruction_expander_top.sv
test/compressed_instruction_expander_top_tb.sv
